/* rtl/core/text_console_writer_core_macros.svh */
// ----------------------------------------------------------------------------
// text_console_writer_core_macros.svh
// Assertion macros for the text console writer. They expand to concurrent
// assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check on every clk edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clk edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, widths and codes of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int CODE_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int LOC_W     = 11;
  localparam int CELL_W    = 16;
  localparam int COLOUR_W  = 4;
  localparam int CFG_IDX_W = 2;

  // Operations
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

  localparam logic [COLOUR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

  // Control characters
  localparam logic [CODE_W-1:0] CH_BS  = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CODE_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CODE_W-1:0] CH_PRINT_HI = 8'h7F;

  localparam int TAB_STOP = 8;

  // White space on black
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/tcw_if.sv */
// ----------------------------------------------------------------------------
// tcw_in_if / tcw_out_if
// Valid/ready channels of the text console writer: operation requests in,
// cursor and cell results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CODE_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, output func, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input func, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [LOC_W-1:0]  cursor_location;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, output cursor_location, output cell_value,
                  input ready);
  modport sink   (input valid, input cursor_location, input cell_value,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/text_console_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine: a COLUMNS x ROWS screen of character/attribute
// cells with a cursor, put/clear/read operations and scrolling.
//
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        func, char_code, cell_index
//   out_chan  out  valid/ready        cursor_location, cell_value
//   cfg_*     in   cfg_we, no ready   cfg_idx, cfg_wdata
//
// Put of a character or control code, read, and unused operation: the
// execute and response steps. Clear: blanks every cell and homes the cursor. A put that
// scrolls copies the rows up and fills the last row; the screen memory has
// one write port and one registered read port, and is swept one cell per
// cycle by the address counter. After reset a clearing pass writes every
// cell once while in_chan.ready stays low. A stalled result waits in the
// output register; the next transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_core_macros.svh"

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tcw_in_if.sink                          in_chan,
  tcw_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tcw_pkg::COLOUR_W-1:0]    cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int CNTW       = $clog2(CELLS + 1);
  localparam int CW         = $clog2(COLUMNS + TAB_STOP);
  localparam int RW         = $clog2(ROWS + 1);
  localparam int LAST_START = (ROWS - 1) * COLUMNS;

  // Screen memory and its ports
  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] rd_data_r;

  // Sequencer and cursor
  state_t            state_r, state_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              hit_r, hit_nxt;

  // Latched transaction
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;

  // Attribute registers
  logic [COLOUR_W-1:0] fg_r;
  logic [COLOUR_W-1:0] bg_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [LOC_W-1:0]  out_loc_r, out_loc_nxt;
  logic [CELL_W-1:0] out_val_r, out_val_nxt;

  logic              in_ready;
  logic [CNTW-1:0]   lin;
  logic [CW-1:0]     put_col;
  logic [RW-1:0]     put_row;
  logic              put_wr;

  // Linear cursor position
  assign lin = CNTW'(row_r) * CNTW'(COLUMNS) + CNTW'(col_r);

  // Interpret one put code against the current cursor
  always_comb begin
    put_col = col_r;
    put_row = row_r;
    put_wr  = 1'b0;
    case (code_r)
      CH_BS: begin
        if (col_r != '0) put_col = col_r - 1'b1;
      end
      CH_TAB: begin
        put_col = (col_r + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);
      end
      CH_CR: begin
        put_col = '0;
      end
      CH_LF: begin
        put_col = '0;
        put_row = row_r + 1'b1;
      end
      default: begin
        if (code_r inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
          put_wr  = 1'b1;
          put_col = col_r + 1'b1;
        end
      end
    endcase
    // wrap at the right margin
    if (put_col >= CW'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
  end

  // Sequencer: next state, memory port control and results
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    waddr_nxt     = waddr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    hit_nxt       = hit_r;
    func_nxt      = func_r;
    code_nxt      = code_r;
    index_nxt     = index_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_loc_nxt   = out_loc_r;
    out_val_nxt   = out_val_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = BLANK_CELL;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[AW-1:0];

    case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        if (cnt_r == CNTW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          func_nxt  = in_chan.func;
          code_nxt  = in_chan.char_code;
          index_nxt = in_chan.cell_index;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        hit_nxt = 1'b0;
        case (func_r)
          FUNC_PUT: begin
            mem_we    = put_wr;
            mem_waddr = lin[AW-1:0];
            mem_wdata = {bg_r, fg_r, code_r};
            col_nxt   = put_col;
            if (put_row == RW'(ROWS)) begin
              // scroll: copy rows up starting from the second row
              row_nxt   = RW'(ROWS - 1);
              cnt_nxt   = CNTW'(COLUMNS);
              pend_nxt  = 1'b0;
              state_nxt = ST_SCROLL;
            end else begin
              row_nxt   = put_row;
              state_nxt = ST_RESP;
            end
          end
          FUNC_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_FILL;
          end
          FUNC_READ: begin
            hit_nxt   = (32'(index_r) < CELLS);
            mem_re    = (32'(index_r) < CELLS);
            mem_raddr = AW'(index_r);
            state_nxt = ST_RESP;
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end

      ST_SCROLL: begin
        // read source cell, write the one fetched in the previous cycle
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = waddr_r;
          mem_wdata = rd_data_r;
        end
        if (32'(cnt_r) < CELLS) begin
          mem_re    = 1'b1;
          pend_nxt  = 1'b1;
          waddr_nxt = AW'(cnt_r - CNTW'(COLUMNS));
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          cnt_nxt   = CNTW'(LAST_START);
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = ST_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_loc_nxt   = LOC_W'(lin);
          out_val_nxt   = hit_r ? rd_data_r : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    waddr_r   <= waddr_nxt;
    func_r    <= func_nxt;
    code_r    <= code_nxt;
    index_r   <= index_nxt;
    out_loc_r <= out_loc_nxt;
    out_val_r <= out_val_nxt;
  end

  // Attribute configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FOREGROUND: fg_r <= cfg_wdata;
        CFG_BACKGROUND: bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // Drive the channels
  assign in_chan.ready            = in_ready;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.cursor_location = out_loc_r;
  assign out_chan.cell_value      = out_val_r;

  // Checks
  `TCW_ASSERT(a_accept_to_exec, (in_chan.valid && in_chan.ready) |=> (state_r == ST_EXEC), "accepted transaction did not start execution")
  `TCW_ASSERT(a_write_in_range, mem_we |-> (32'(mem_waddr) < CELLS), "screen write outside the screen")
  `TCW_ASSERT(a_cursor_in_range, (state_r == ST_IDLE) |-> ((32'(row_r) < ROWS) && (32'(col_r) < COLUMNS)), "cursor outside the screen while idle")
  `TCW_ASSERT(a_result_from_resp, $rose(out_valid_r) |-> $past(state_r == ST_RESP), "result raised outside the response step")
  `TCW_ASSERT_ALWAYS(a_no_accept_in_init, (state_r == ST_INIT) |-> !in_chan.ready, "ready during the clearing pass")

endmodule

`default_nettype wire
